// ===== rtl/rid2sid_pkg.sv =====
// Shared types, codes and constants of the requester ID to stream ID map.
package rid2sid_pkg;

    localparam int DEF_ENTRIES = 16;
    // Queue between front and back; depth must be a power of two.
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_HIT      = 2'd2,
        ST_MISS     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RESP
    } bk_state_t;

    // Classified transaction handed from front to back.
    typedef struct packed {
        op_t         op;
        logic [7:0]  root;
        logic [31:0] key;     // requester ID on a query, range base on an insert
        logic [31:0] hi;      // range end, modulo 2^32
        logic [31:0] offset;  // out_base minus range base, modulo 2^32
        logic [7:0]  ttag;
    } item_t;

    // One stored table entry.
    typedef struct packed {
        logic [7:0]  root;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] offset;
        logic [7:0]  ttag;
    } entry_t;

endpackage

// ===== rtl/requester_id_to_stream_id_map.sv =====
// Top level of the requester ID to stream ID map.
//
// Range-based ID translation table of up to ENTRIES entries kept in insertion
// order. An insert transaction (op 0) appends an entry {root_tag, range_base,
// range_count, out_base, translator_tag} and answers status 0, or status 1
// when the table is full. A query transaction (op 1) scans the entries from
// oldest to newest; the first one with a matching root tag whose range
// [base, base + count mod 2^32) holds requester_id answers status 2 with
// stream_id = requester_id - base + out_base (mod 2^32) and its translator
// tag; otherwise status 3. Non-hit results carry zero in stream_id and
// translator_out. The table is empty after reset and needs no clearing pass.
// Timing: the front queue accepts transactions while the back works, so
// req_stall only rises when the two-deep queue is full. The back handles one
// transaction at a time. An insert, and a query on an empty table, go from
// idle straight to the response state; any other query first scans the
// stored entries from oldest to newest and stops at the first hit or after
// the last entry. The scan length is set by the single read port of the
// entry RAM, which delivers one entry per cycle. The result sits in an
// output register, so the back moves on as soon as that register is empty
// or rsp_stall is low.
module requester_id_to_stream_id_map
    import rid2sid_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [7:0]  root_tag,
    input  logic [31:0] requester_id,
    input  logic [31:0] range_base,
    input  logic [31:0] range_count,
    input  logic [31:0] out_base,
    input  logic [7:0]  translator_tag,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] stream_id,
    output logic [7:0]  translator_out
);

    logic  q_vld;
    logic  q_pop;
    item_t q_item;

    // Accept and classify transactions; precompute range end and offset.
    rid2sid_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .root_tag       (root_tag),
        .requester_id   (requester_id),
        .range_base     (range_base),
        .range_count    (range_count),
        .out_base       (out_base),
        .translator_tag (translator_tag),
        .q_vld          (q_vld),
        .q_pop          (q_pop),
        .q_item         (q_item)
    );

    // Insert into or scan the table and hold the result until taken.
    rid2sid_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_vld          (q_vld),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .stream_id      (stream_id),
        .translator_out (translator_out)
    );

endmodule

// ===== rtl/rid2sid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rid2sid_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rid2sid_front.sv =====
// Front end: accept transactions, precompute range end and offset, queue them.
module rid2sid_front
    import rid2sid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [7:0]  root_tag,
    input  logic [31:0] requester_id,
    input  logic [31:0] range_base,
    input  logic [31:0] range_count,
    input  logic [31:0] out_base,
    input  logic [7:0]  translator_tag,
    output logic        q_vld,
    input  logic        q_pop,
    output item_t       q_item
);

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    item_t          fifo_reg [Q_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;
    logic           push;
    item_t          new_item;

    assign req_stall = (fill_reg == QCW'(Q_DEPTH));
    assign push      = req_valid && !req_stall;
    assign q_vld     = (fill_reg != '0);
    assign q_item    = fifo_reg[rd_ptr_reg];

    // Classify: a query carries its ID, an insert its base, precomputed end and offset.
    always_comb
    begin
        new_item.op     = op_t'(op);
        new_item.root   = root_tag;
        new_item.key    = (op_t'(op) == OP_QUERY) ? requester_id : range_base;
        new_item.hi     = range_base + range_count;
        new_item.offset = out_base - range_base;
        new_item.ttag   = translator_tag;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QCW'(push) - QCW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/rid2sid_back.sv =====
// Back end: table insert and in-order range scan, with the result register.
module rid2sid_back
    import rid2sid_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_vld,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] stream_id,
    output logic [7:0]  translator_out
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = $bits(entry_t);

    bk_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic           chk_vld_reg, chk_vld_next;
    item_t          cur_reg, cur_next;
    status_t        res_st_reg, res_st_next;
    logic [31:0]    res_sid_reg, res_sid_next;
    logic [7:0]     res_tag_reg, res_tag_next;
    logic           out_vld_reg, out_vld_next;
    status_t        out_st_reg;
    logic [31:0]    out_sid_reg;
    logic [7:0]     out_tag_reg;

    logic           ram_we, ram_rd;
    entry_t         wr_ent, rd_ent;
    logic [ENT_W-1:0] rd_raw;
    logic           hit, has_room, scan_left, slot_free;

    assign wr_ent.root   = q_item.root;
    assign wr_ent.lo     = q_item.key;
    assign wr_ent.hi     = q_item.hi;
    assign wr_ent.offset = q_item.offset;
    assign wr_ent.ttag   = q_item.ttag;

    rid2sid_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_ent),
        .rd_en   (ram_rd),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_raw)
    );

    assign rd_ent    = entry_t'(rd_raw);
    assign has_room  = (count_reg < CNT_W'(ENTRIES));
    assign scan_left = (issue_reg < count_reg);
    assign slot_free = !out_vld_reg || !rsp_stall;
    assign hit       = chk_vld_reg && (rd_ent.root == cur_reg.root)
                       && (cur_reg.key >= rd_ent.lo) && (cur_reg.key < rd_ent.hi);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_vld)
                begin
                    if (q_item.op == OP_INSERT || count_reg == '0)
                    begin
                        state_next = BK_RESP;
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                if (hit || (!scan_left && !chk_vld_reg))
                begin
                    state_next = BK_RESP;
                end
            end
            BK_RESP:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_rd       = 1'b0;
        count_next   = count_reg;
        issue_next   = issue_reg;
        chk_vld_next = 1'b0;
        cur_next     = cur_reg;
        res_st_next  = res_st_reg;
        res_sid_next = res_sid_reg;
        res_tag_next = res_tag_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_vld)
                begin
                    q_pop        = 1'b1;
                    cur_next     = q_item;
                    res_sid_next = '0;
                    res_tag_next = '0;
                    issue_next   = '0;
                    if (q_item.op == OP_INSERT)
                    begin
                        if (has_room)
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            res_st_next = ST_INSERTED;
                        end
                        else
                        begin
                            res_st_next = ST_FULL;
                        end
                    end
                    else
                    begin
                        res_st_next = ST_MISS;
                    end
                end
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    // First match in insertion order wins; drop the rest.
                    res_st_next  = ST_HIT;
                    res_sid_next = cur_reg.key + rd_ent.offset;
                    res_tag_next = rd_ent.ttag;
                end
                else if (scan_left)
                begin
                    ram_rd       = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                    chk_vld_next = 1'b1;
                end
            end
            BK_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == BK_RESP && slot_free)
        begin
            out_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        res_st_reg  <= res_st_next;
        res_sid_reg <= res_sid_next;
        res_tag_reg <= res_tag_next;
        if (state_reg == BK_RESP && slot_free)
        begin
            out_st_reg  <= res_st_reg;
            out_sid_reg <= res_sid_reg;
            out_tag_reg <= res_tag_reg;
        end
    end

    assign rsp_valid      = out_vld_reg;
    assign status         = out_st_reg;
    assign stream_id      = out_sid_reg;
    assign translator_out = out_tag_reg;

endmodule
